>>> rtl/core/wsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types and constants of the wav stream decoder
// ----------------------------------------------------------------------------
package wsd_pkg;

  // result kinds
  localparam logic [1:0] KIND_FORMAT = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_RIFF   = 3'd0;
  localparam logic [2:0] ERR_FMTID  = 3'd1;
  localparam logic [2:0] ERR_FORMAT = 3'd2;
  localparam logic [2:0] ERR_DEPTH  = 3'd3;
  localparam logic [2:0] ERR_JUNK   = 3'd4;
  localparam logic [2:0] ERR_NODATA = 3'd5;

  // chunk tags, little endian
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_JUNK = 32'h4B4E_554A;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] ASSUMED_RATE = 32'd44100;

  // sample kinds handed to the back end
  localparam logic [1:0] SK_16 = 2'd0;
  localparam logic [1:0] SK_24 = 2'd1;
  localparam logic [1:0] SK_FL = 2'd2;

  // word from front end to back end
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  skind;
    logic [31:0] raw;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [5:0]  bits;
    logic        assumed;
    logic [2:0]  err;
  } wsd_word_t;

  // result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] smp;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [5:0]  bits;
    logic        assumed;
    logic [2:0]  err;
  } wsd_res_t;

endpackage
`default_nettype wire

>>> rtl/core/wsd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_front
// byte parser: header, chunk walk and sample assembly
// ----------------------------------------------------------------------------
module wsd_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_sof,
  input  wire logic              in_eof,
  output logic                   wr_en,
  output wsd_pkg::wsd_word_t     wr_word
);

  typedef enum logic [8:0] {
    PH_HDR   = 9'b000000001,
    PH_FMT   = 9'b000000010,
    PH_JSKIP = 9'b000000100,
    PH_JNEXT = 9'b000001000,
    PH_CHUNK = 9'b000010000,
    PH_SKIP  = 9'b000100000,
    PH_DATA  = 9'b001000000,
    PH_DONE  = 9'b010000000,
    PH_HALT  = 9'b100000000
  } phase_t;

  phase_t      phase_r, phase_nxt, ph;
  logic [4:0]  off_r, off_nxt, off;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [15:0] fmt_r, fmt_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] dleft_r, dleft_nxt;
  logic [31:0] smp_r, smp_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        junk_r, junk_nxt;
  logic [3:0]  err;
  logic [1:0]  last;

  // state update, one byte a cycle while in_valid is high
  always_comb begin
    ph        = in_sof ? PH_HDR : phase_r;
    off       = in_sof ? 5'd0 : off_r;
    tag_nxt   = {in_byte, tag_r[31:8]};
    phase_nxt = ph;
    off_nxt   = off;
    skip_nxt  = in_sof ? 32'd0 : skip_r;
    fmt_nxt   = in_sof ? 16'd0 : fmt_r;
    chan_nxt  = in_sof ? 16'd0 : chan_r;
    rate_nxt  = in_sof ? 32'd0 : rate_r;
    bits_nxt  = in_sof ? 16'd0 : bits_r;
    dleft_nxt = in_sof ? 32'd0 : dleft_r;
    smp_nxt   = in_sof ? 32'd0 : smp_r;
    pos_nxt   = in_sof ? 2'd0 : pos_r;
    junk_nxt  = in_sof ? 1'b0 : junk_r;
    if (in_sof) tag_nxt = {in_byte, 24'd0};
    err       = 4'd8;
    last      = bits_r[4:3] - 2'd1;
    if (bits_r == 16'd32) last = 2'd3;
    wr_en     = 1'b0;
    wr_word   = '0;
    case (ph)
      PH_HDR: begin
        off_nxt = off + 5'd1;
        if (off == 5'd3 && tag_nxt != wsd_pkg::TAG_RIFF) err = {1'b0, wsd_pkg::ERR_RIFF};
        else if (off == 5'd11 && tag_nxt != wsd_pkg::TAG_WAVE)
          err = {1'b0, wsd_pkg::ERR_RIFF};
        else if (off == 5'd15) begin
          if (tag_nxt == wsd_pkg::TAG_JUNK) junk_nxt = 1'b1;
          else if (tag_nxt != wsd_pkg::TAG_FMT) err = {1'b0, wsd_pkg::ERR_FMTID};
        end else if (off == 5'd19) begin
          off_nxt = 5'd0;
          if (junk_nxt) begin
            skip_nxt  = tag_nxt;
            phase_nxt = (tag_nxt != 32'd0) ? PH_JSKIP : PH_JNEXT;
          end else begin
            phase_nxt = PH_FMT;
          end
        end
      end
      PH_FMT: begin
        off_nxt = off + 5'd1;
        if (off == 5'd1) fmt_nxt = tag_nxt[31:16];
        else if (off == 5'd3) chan_nxt = tag_nxt[31:16];
        else if (off == 5'd7) rate_nxt = tag_nxt;
        else if (off == 5'd15) begin
          bits_nxt = tag_nxt[31:16];
          if (fmt_nxt != 16'd1 && fmt_nxt != 16'd3) err = {1'b0, wsd_pkg::ERR_FORMAT};
          else if (bits_nxt != 16'd16 && bits_nxt != 16'd24 && bits_nxt != 16'd32)
            err = {1'b0, wsd_pkg::ERR_DEPTH};
          off_nxt   = 5'd0;
          phase_nxt = PH_CHUNK;
        end
      end
      PH_JSKIP, PH_SKIP: begin
        skip_nxt = skip_r - 32'd1;
        if (skip_nxt == 32'd0) begin
          phase_nxt = (ph == PH_JSKIP) ? PH_JNEXT : PH_CHUNK;
          off_nxt   = 5'd0;
        end
      end
      PH_JNEXT, PH_CHUNK: begin
        off_nxt = off + 5'd1;
        if (off == 5'd3) smp_nxt = tag_nxt;
        if (off == 5'd7) begin
          off_nxt = 5'd0;
          if (ph == PH_JNEXT && smp_nxt == wsd_pkg::TAG_FMT) begin
            phase_nxt = PH_FMT;
          end else if (smp_nxt == wsd_pkg::TAG_DATA) begin
            if (ph == PH_JNEXT) begin
              fmt_nxt  = 16'd1;
              chan_nxt = 16'd2;
              rate_nxt = wsd_pkg::ASSUMED_RATE;
              bits_nxt = 16'd16;
            end
            dleft_nxt = tag_nxt;
            smp_nxt   = 32'd0;
            pos_nxt   = 2'd0;
            phase_nxt = (tag_nxt != 32'd0) ? PH_DATA : PH_DONE;
            wr_en         = 1'b1;
            wr_word.kind  = wsd_pkg::KIND_FORMAT;
            wr_word.chans = chan_nxt;
            wr_word.rate  = rate_nxt;
            wr_word.bits  = bits_nxt[5:0];
            wr_word.assumed = (ph == PH_JNEXT);
          end else if (ph == PH_JNEXT) begin
            err = {1'b0, wsd_pkg::ERR_JUNK};
          end else begin
            skip_nxt = tag_nxt;
            if (tag_nxt != 32'd0) phase_nxt = PH_SKIP;
          end
        end
      end
      PH_DATA: begin
        smp_nxt   = {in_byte, smp_r[31:8]};
        dleft_nxt = dleft_r - 32'd1;
        if (pos_r >= last) begin
          wr_en        = 1'b1;
          wr_word.kind = wsd_pkg::KIND_SAMPLE;
          wr_word.raw  = smp_nxt;
          wr_word.skind = (bits_r == 16'd16) ? wsd_pkg::SK_16 :
                          (bits_r == 16'd24) ? wsd_pkg::SK_24 : wsd_pkg::SK_FL;
          pos_nxt = 2'd0;
        end else begin
          pos_nxt = pos_r + 2'd1;
        end
        if (dleft_nxt == 32'd0) phase_nxt = PH_DONE;
      end
      default: ;
    endcase
    // error and end of file
    if (err != 4'd8) begin
      wr_en        = 1'b1;
      wr_word      = '0;
      wr_word.kind = wsd_pkg::KIND_ERROR;
      wr_word.err  = err[2:0];
      phase_nxt    = PH_HALT;
    end
    if (in_eof) begin
      if (!wr_en && (ph == PH_HDR || ph == PH_FMT || ph == PH_JSKIP || ph == PH_JNEXT ||
                     ph == PH_CHUNK || ph == PH_SKIP)) begin
        wr_en        = 1'b1;
        wr_word      = '0;
        wr_word.kind = wsd_pkg::KIND_ERROR;
        wr_word.err  = wsd_pkg::ERR_NODATA;
      end
      phase_nxt = PH_HALT;
    end
    wr_en = wr_en & in_valid;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      off_r   <= '0;
      tag_r   <= '0;
      skip_r  <= '0;
      fmt_r   <= '0;
      chan_r  <= '0;
      rate_r  <= '0;
      bits_r  <= '0;
      dleft_r <= '0;
      smp_r   <= '0;
      pos_r   <= '0;
      junk_r  <= 1'b0;
    end else if (in_valid) begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      tag_r   <= tag_nxt;
      skip_r  <= skip_nxt;
      fmt_r   <= fmt_nxt;
      chan_r  <= chan_nxt;
      rate_r  <= rate_nxt;
      bits_r  <= bits_nxt;
      dleft_r <= dleft_nxt;
      smp_r   <= smp_nxt;
      pos_r   <= pos_nxt;
      junk_r  <= junk_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/wsd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_queue
// four-entry queue between parser and sample converter
// ----------------------------------------------------------------------------
module wsd_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wsd_pkg::wsd_word_t      wr_word,
  output logic                    space,
  output logic                    rd_valid,
  input  wire logic               rd_en,
  output wsd_pkg::wsd_word_t      rd_word
);

  wsd_pkg::wsd_word_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign rd_valid = (cnt_r != 3'd0);
  assign space    = (cnt_r < 3'd3);
  assign rd_word  = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_word;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr_en} - {2'd0, rd_en};
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/wsd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_back
// sample conversion to q1.23 and output register
// ----------------------------------------------------------------------------
module wsd_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               rd_valid,
  output logic                    rd_en,
  input  wsd_pkg::wsd_word_t      rd_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output wsd_pkg::wsd_res_t       out_res
);

  logic              vld_r;
  wsd_pkg::wsd_res_t res_r, res_nxt;
  logic [7:0]  e;
  logic [22:0] m;
  logic [23:0] mant, mag;
  logic [7:0]  sh;
  logic [24:0] rnd;
  logic [23:0] q;

  // float to q1.23, round half away
  always_comb begin
    e    = rd_word.raw[30:23];
    m    = rd_word.raw[22:0];
    mant = (e == 8'd0) ? {1'b0, m} : {1'b1, m};
    sh   = (e == 8'd0) ? 8'd126 : 8'd127 - e;
    rnd  = {1'b0, mant} + (25'd1 << (sh[4:0] - 5'd1));
    mag  = (sh > 8'd25) ? 24'd0 : 24'(rnd >> sh[4:0]);
    if (e == 8'hFF && m != 23'd0) q = 24'h7FFFFF;
    else if (e >= 8'd127) q = rd_word.raw[31] ? 24'h800000 : 24'h7FFFFF;
    else if (!rd_word.raw[31]) q = (mag > 24'h7FFFFF) ? 24'h7FFFFF : mag;
    else q = 24'd0 - mag;
    res_nxt         = '0;
    res_nxt.kind    = rd_word.kind;
    res_nxt.chans   = rd_word.chans;
    res_nxt.rate    = rd_word.rate;
    res_nxt.bits    = rd_word.bits;
    res_nxt.assumed = rd_word.assumed;
    res_nxt.err     = rd_word.err;
    if (rd_word.kind == wsd_pkg::KIND_SAMPLE) begin
      case (rd_word.skind)
        wsd_pkg::SK_16: res_nxt.smp = {rd_word.raw[31:16], 8'd0};
        wsd_pkg::SK_24: res_nxt.smp = rd_word.raw[31:8];
        default:        res_nxt.smp = q;
      endcase
    end
  end

  assign rd_en     = rd_valid && (!vld_r || out_ready);
  assign out_valid = vld_r;
  assign out_res   = res_r;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (!vld_r || out_ready) vld_r <= rd_valid;
  end

  always_ff @(posedge clk) begin
    if (rd_en) res_r <= res_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/core/wav_stream_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wav_stream_decoder
// streaming riff/wave parser giving format, q1.23 samples or an error
// ----------------------------------------------------------------------------
// Input channel: one file byte per word, tuser = start_of_file,
// tlast = end_of_file.
// Output channel: one result per word: format, sample or error code.
// The front parser takes one byte a cycle while in_tready is high and
// updates its state in that cycle; results go through a four-entry queue
// to the converter, which registers the output. A result goes through the
// queue and the output register to out_tvalid. Unstalled throughput is one
// byte per cycle; the limit is the parser's single state register.
// When the receiver stalls, the queue fills and in_tready drops once fewer
// than two entries are free; it rises again as results drain.
// Reset (synchronous) returns the parser to the file header and empties the
// queue and output register.
// ----------------------------------------------------------------------------
module wav_stream_decoder (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // data_byte
  input  wire logic         in_tuser,   // start_of_file
  input  wire logic         in_tlast,   // end_of_file
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [87:0]       out_tdata,  // sample_value, out_channels, out_sample_rate,
                                        // out_bits, assumed_format, error_code, zero fill
  output logic [1:0]        out_tuser   // result_kind
);

  logic               acc, wr_en, space, rd_valid, rd_en;
  wsd_pkg::wsd_word_t wr_word, rd_word;
  wsd_pkg::wsd_res_t  res;

  assign in_tready = space;
  assign acc       = in_tvalid & in_tready;

  wsd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(acc), .in_byte(in_tdata),
    .in_sof(in_tuser), .in_eof(in_tlast), .wr_en(wr_en), .wr_word(wr_word)
  );

  wsd_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_word(wr_word), .space(space),
    .rd_valid(rd_valid), .rd_en(rd_en), .rd_word(rd_word)
  );

  wsd_back u_back (
    .clk(clk), .rst_n(rst_n), .rd_valid(rd_valid), .rd_en(rd_en), .rd_word(rd_word),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  // output packing
  assign out_tuser = res.kind;
  assign out_tdata = {6'd0, res.err, res.assumed, res.bits, res.rate, res.chans, res.smp};

  // checks
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3) else $error("bad result kind");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> acc) else $error("queue written without byte");

endmodule
`default_nettype wire
